// File: hw/rtl/bmcc_pkg.sv
// Shared types and codes for the bitmask code compressor.
package bmcc_pkg;

  // Request actions
  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_COMPRESS = 2'd1;
  localparam logic [1:0] ACT_FLUSH    = 2'd2;

  // Result formats
  localparam logic [2:0] FMT_RAW      = 3'd0;
  localparam logic [2:0] FMT_RUN      = 3'd1;
  localparam logic [2:0] FMT_BITMASK  = 3'd2;
  localparam logic [2:0] FMT_ONE_BIT  = 3'd3;
  localparam logic [2:0] FMT_TWO_CONS = 3'd4;
  localparam logic [2:0] FMT_FOUR_CON = 3'd5;
  localparam logic [2:0] FMT_TWO_ANY  = 3'd6;
  localparam logic [2:0] FMT_DICT     = 3'd7;

  // Field widths fixed by the channel format
  localparam int POS_W  = 5;
  localparam int SLOT_W = 4;
  localparam int RUN_W  = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  entry_slot;
    logic [31:0] word;
  } request_t;

  typedef struct packed {
    logic [2:0]  format;
    logic [2:0]  run_count;
    logic [4:0]  first_position;
    logic [4:0]  second_position;
    logic [3:0]  mask;
    logic [3:0]  dict_slot;
    logic [31:0] raw_word;
    logic        last;
  } result_t;

  // Candidate record handed along the cell chain
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              one_ok;
    logic [POS_W-1:0]  one_pos;
    logic [SLOT_W-1:0] one_slot;
    logic              two_ok;
    logic [POS_W-1:0]  two_pos;
    logic [SLOT_W-1:0] two_slot;
    logic              four_ok;
    logic [POS_W-1:0]  four_pos;
    logic [SLOT_W-1:0] four_slot;
    logic              bm_ok;
    logic [POS_W-1:0]  bm_pos;
    logic [3:0]        bm_mask;
    logic [SLOT_W-1:0] bm_slot;
    logic              any_ok;
    logic [POS_W-1:0]  any_first;
    logic [POS_W-1:0]  any_second;
    logic [SLOT_W-1:0] any_slot;
  } scan_t;

endpackage

// File: hw/rtl/bmcc_stream_if.sv
// Valid/ready stream channel carrying one request or result.
interface bmcc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bmcc_cell.sv
// One dictionary cell: holds an entry and folds its match codes into the passing record.
module bmcc_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX       = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bmcc_pkg::SLOT_W-1:0]    wr_slot,
  input  logic [WORD_BITS-1:0]           wr_data,
  input  logic [WORD_BITS-1:0]           word_in,
  input  bmcc_pkg::scan_t                scan_in,
  output logic [WORD_BITS-1:0]           word_out,
  output bmcc_pkg::scan_t                scan_out
);

  localparam logic [bmcc_pkg::SLOT_W-1:0] SLOT = bmcc_pkg::SLOT_W'(IDX);
  localparam logic [bmcc_pkg::POS_W-1:0]  TOP  = bmcc_pkg::POS_W'(WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0]        ONE  = {{(WORD_BITS-1){1'b0}}, 1'b1};

  logic [WORD_BITS-1:0]         entry;
  logic [WORD_BITS-1:0]         diff;
  logic [WORD_BITS-1:0]         shifted;
  logic [WORD_BITS-1:0]         oh_hi;
  logic [WORD_BITS-1:0]         oh_lo;
  logic [bmcc_pkg::POS_W-1:0]   hi;
  logic [bmcc_pkg::POS_W-1:0]   lo;
  logic [bmcc_pkg::POS_W-1:0]   fp;
  logic [bmcc_pkg::POS_W-1:0]   lp;
  logic [bmcc_pkg::POS_W-1:0]   span;
  logic [3:0]                   m;
  logic                         nz;
  bmcc_pkg::scan_t              scan_next;

  // Dictionary entry, written by a load to this slot
  always_ff @(posedge clk) begin
    if (wr_en && wr_slot == SLOT) begin
      entry <= wr_data;
    end
  end

  // Mismatch analysis: first and last differing positions, window mask
  always_comb begin
    diff = entry ^ word_in;
    nz   = |diff;
    hi   = '0;
    lo   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (diff[i]) hi = bmcc_pkg::POS_W'(i);
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (diff[i]) lo = bmcc_pkg::POS_W'(i);
    end
    fp      = TOP - hi;
    lp      = TOP - lo;
    span    = lp - fp;
    shifted = diff << fp;
    m       = shifted[WORD_BITS-1 -: 4];
    oh_hi   = ONE << hi;
    oh_lo   = ONE << lo;
  end

  // Keep the lowest-numbered qualifying entry for each method
  always_comb begin
    scan_next = scan_in;
    if (!scan_in.hit && !nz) begin
      scan_next.hit      = 1'b1;
      scan_next.hit_slot = SLOT;
    end
    if (!scan_in.one_ok && nz && span == '0) begin
      scan_next.one_ok   = 1'b1;
      scan_next.one_pos  = fp;
      scan_next.one_slot = SLOT;
    end
    if (!scan_in.two_ok && nz && span == bmcc_pkg::POS_W'(1)) begin
      scan_next.two_ok   = 1'b1;
      scan_next.two_pos  = fp;
      scan_next.two_slot = SLOT;
    end
    if (!scan_in.four_ok && nz && span == bmcc_pkg::POS_W'(3) && m == 4'hF) begin
      scan_next.four_ok   = 1'b1;
      scan_next.four_pos  = fp;
      scan_next.four_slot = SLOT;
    end
    if (!scan_in.bm_ok && nz && span <= bmcc_pkg::POS_W'(3)) begin
      scan_next.bm_ok   = 1'b1;
      scan_next.bm_pos  = fp;
      scan_next.bm_mask = m;
      scan_next.bm_slot = SLOT;
    end
    if (!scan_in.any_ok && nz && span != '0 && (diff ^ oh_hi ^ oh_lo) == '0) begin
      scan_next.any_ok     = 1'b1;
      scan_next.any_first  = fp;
      scan_next.any_second = lp;
      scan_next.any_slot   = SLOT;
    end
  end

  // Hand the record and word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
    word_out <= word_in;
  end

endmodule

// File: hw/rtl/bitmask_code_compressor_unit.sv
// Top level of the bitmask code compressor: run tracking, cell chain and result register.
// Usage:
//   request channel carries action, entry_slot and word. A load writes one
//   dictionary entry; a compress encodes one word; a flush closes the stream.
//   result channel carries one code per item; last marks the final result of
//   a request. A compress may give two results: a pending run, then its code.
// All entries must be loaded before the first compress.
// Timing:
//   Loads, flushes and absorbed repeats leave the block idle, so the next
//   request can be taken as soon as the output register allows. A compress
//   that is encoded walks the word through DICT_ENTRIES registered cells;
//   its code goes to the hold register, then into the output register once
//   that is free, and no new request is taken until the block is idle again.
// Stalls:
//   Results sit in a single output register until taken. While it is full
//   and not being taken, no new request is accepted and a finished code
//   waits in a hold register.
// Reset (rst, synchronous): clears run tracking, the chain and the output
//   register. Dictionary contents survive and must be reloaded as needed.
module bitmask_code_compressor_unit #(
  parameter int DICT_ENTRIES = 16,
  parameter int WORD_BITS    = 32,
  parameter int MAX_RUN      = 8
) (
  input  logic         clk,
  input  logic         rst,
  bmcc_stream_if.sink   request,
  bmcc_stream_if.source result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam logic [bmcc_pkg::RUN_W-1:0] RUN_MAX = bmcc_pkg::RUN_W'(MAX_RUN);

  state_t                       state;
  logic [WORD_BITS-1:0]         prev_word;
  logic                         have_prev;
  logic [bmcc_pkg::RUN_W-1:0]   pending;
  bmcc_pkg::result_t            out_data;
  logic                         out_valid;
  bmcc_pkg::result_t            hold;

  bmcc_pkg::request_t           req;
  logic                         accept;
  logic                         slot_free;
  logic [WORD_BITS-1:0]         w;
  logic                         absorb;
  logic                         encode_go;
  logic                         out_fill;
  bmcc_pkg::result_t            run_res;
  bmcc_pkg::result_t            code_res;

  bmcc_pkg::scan_t              scan  [DICT_ENTRIES+1];
  logic [WORD_BITS-1:0]         wpipe [DICT_ENTRIES+1];

  assign req       = request.data;
  assign slot_free = !out_valid || result.ready;
  assign request.ready = (state == ST_IDLE) && slot_free;
  assign accept    = request.valid && request.ready;
  assign w         = req.word[WORD_BITS-1:0];
  assign absorb    = have_prev && w == prev_word && pending < RUN_MAX;
  assign encode_go = accept && req.action == bmcc_pkg::ACT_COMPRESS && !absorb;

  // Output register takes a run code on a request or a finished code
  assign out_fill = (accept && pending != '0 &&
                     (req.action == bmcc_pkg::ACT_FLUSH ||
                      (req.action == bmcc_pkg::ACT_COMPRESS && !absorb))) ||
                    (state == ST_DONE && slot_free);

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Run code for the pending repeats; final only when a flush closes the run
  always_comb begin
    run_res           = '0;
    run_res.format    = bmcc_pkg::FMT_RUN;
    run_res.run_count = 3'(pending - bmcc_pkg::RUN_W'(1));
    run_res.last      = (req.action == bmcc_pkg::ACT_FLUSH);
  end

  // Chain entry: fresh record with the word to be encoded
  always_comb begin
    scan[0]       = '0;
    scan[0].valid = encode_go;
    wpipe[0]      = w;
  end

  // Dictionary cells
  for (genvar g = 0; g < DICT_ENTRIES; g++) begin : g_cell
    bmcc_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (accept && req.action == bmcc_pkg::ACT_LOAD),
      .wr_slot  (req.entry_slot),
      .wr_data  (w),
      .word_in  (wpipe[g]),
      .scan_in  (scan[g]),
      .word_out (wpipe[g+1]),
      .scan_out (scan[g+1])
    );
  end

  // Final choice of code from the record leaving the last cell
  always_comb begin
    code_res      = '0;
    code_res.last = 1'b1;
    if (scan[DICT_ENTRIES].hit) begin
      code_res.format    = bmcc_pkg::FMT_DICT;
      code_res.dict_slot = scan[DICT_ENTRIES].hit_slot;
    end else if (scan[DICT_ENTRIES].one_ok) begin
      code_res.format         = bmcc_pkg::FMT_ONE_BIT;
      code_res.first_position = scan[DICT_ENTRIES].one_pos;
      code_res.dict_slot      = scan[DICT_ENTRIES].one_slot;
    end else if (scan[DICT_ENTRIES].two_ok) begin
      code_res.format         = bmcc_pkg::FMT_TWO_CONS;
      code_res.first_position = scan[DICT_ENTRIES].two_pos;
      code_res.dict_slot      = scan[DICT_ENTRIES].two_slot;
    end else if (scan[DICT_ENTRIES].four_ok) begin
      code_res.format         = bmcc_pkg::FMT_FOUR_CON;
      code_res.first_position = scan[DICT_ENTRIES].four_pos;
      code_res.dict_slot      = scan[DICT_ENTRIES].four_slot;
    end else if (scan[DICT_ENTRIES].bm_ok) begin
      code_res.format         = bmcc_pkg::FMT_BITMASK;
      code_res.first_position = scan[DICT_ENTRIES].bm_pos;
      code_res.mask           = scan[DICT_ENTRIES].bm_mask;
      code_res.dict_slot      = scan[DICT_ENTRIES].bm_slot;
    end else if (scan[DICT_ENTRIES].any_ok) begin
      code_res.format          = bmcc_pkg::FMT_TWO_ANY;
      code_res.first_position  = scan[DICT_ENTRIES].any_first;
      code_res.second_position = scan[DICT_ENTRIES].any_second;
      code_res.dict_slot       = scan[DICT_ENTRIES].any_slot;
    end else begin
      code_res.format   = bmcc_pkg::FMT_RAW;
      code_res.raw_word = 32'(wpipe[DICT_ENTRIES]);
    end
  end

  // Sequencer, run tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      have_prev <= 1'b0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_fill) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.action)
              bmcc_pkg::ACT_FLUSH: begin
                if (pending != '0) begin
                  out_data <= run_res;
                end
                pending   <= '0;
                have_prev <= 1'b0;
              end
              bmcc_pkg::ACT_COMPRESS: begin
                if (absorb) begin
                  pending <= pending + bmcc_pkg::RUN_W'(1);
                end else begin
                  if (pending != '0) begin
                    out_data <= run_res;
                  end
                  pending   <= '0;
                  prev_word <= w;
                  have_prev <= 1'b1;
                  state     <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan[DICT_ENTRIES].valid) begin
            hold  <= code_res;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_data <= hold;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/bitmask_code_compressor_unit_test.sv
// Self-checking testbench for the bitmask code compressor top level.
`timescale 1ns / 1ps

module bitmask_code_compressor_unit_test;

  localparam int DICT_ENTRIES = 16;
  localparam int WORD_BITS    = 32;
  localparam int MAX_RUN      = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_LIMIT   = 4000;

  // Action code left unused by the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst;

  bmcc_stream_if #(.T(bmcc_pkg::request_t)) request_ch ();
  bmcc_stream_if #(.T(bmcc_pkg::result_t))  result_ch ();

  bitmask_code_compressor_unit #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .WORD_BITS   (WORD_BITS),
    .MAX_RUN     (MAX_RUN)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .request(request_ch),
    .result (result_ch)
  );

  // Requests waiting to be sent and codes waiting to arrive
  bmcc_pkg::request_t pending_requests[$];
  bmcc_pkg::result_t  expected_codes[$];
  int       mismatch_count = 0;
  bit       calm_mode = 1'b0;

  // Predicted state of the block
  logic [31:0] dict_image [DICT_ENTRIES];
  logic [31:0] prev_word;
  bit          have_prev = 1'b0;
  int          run_repeats = 0;

  // Stimulus-side copy of the dictionary, used to build near misses
  logic [31:0] plan_dict [DICT_ENTRIES];
  logic [31:0] plan_last_word;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_idle();
    int r;
    if ($urandom_range(0, 59) == 0) calm_mode = !calm_mode;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Code for a word that is not absorbed into a run
  function automatic bmcc_pkg::result_t encode_word(input logic [31:0] w);
    bmcc_pkg::result_t code;
    logic [31:0] d;
    logic [3:0]  m;
    logic [3:0]  mb;
    int          cnt, first, lastp, q;
    int          s1, s2, s4, sb, sa;
    int          f1, f2, f4, fb, fa, la;
    code = '0;
    for (int e = 0; e < DICT_ENTRIES; e++) begin
      if (dict_image[e] == w) begin
        code.format    = bmcc_pkg::FMT_DICT;
        code.dict_slot = 4'(e);
        return code;
      end
    end
    s1 = -1; s2 = -1; s4 = -1; sb = -1; sa = -1;
    f1 = 0; f2 = 0; f4 = 0; fb = 0; fa = 0; la = 0;
    mb = '0;
    // lowest qualifying entry for each method
    for (int e = 0; e < DICT_ENTRIES; e++) begin
      d = dict_image[e] ^ w;
      if (d == '0) continue;
      cnt = 0; first = -1; lastp = -1;
      for (int p = 0; p < WORD_BITS; p++) begin
        if (d[WORD_BITS-1-p]) begin
          if (first < 0) first = p;
          lastp = p;
          cnt++;
        end
      end
      if (s1 < 0 && cnt == 1) begin s1 = e; f1 = first; end
      if (s2 < 0 && cnt == 2 && lastp == first + 1) begin s2 = e; f2 = first; end
      if (s4 < 0 && cnt == 4 && lastp == first + 3) begin s4 = e; f4 = first; end
      if (sb < 0 && lastp <= first + 3) begin
        m = '0;
        // flags beyond the last bit stay zero
        for (int i = 0; i < 4; i++) begin
          q = first + i;
          if (q < WORD_BITS && d[WORD_BITS-1-q]) m[3-i] = 1'b1;
        end
        sb = e; fb = first; mb = m;
      end
      if (sa < 0 && cnt == 2) begin sa = e; fa = first; la = lastp; end
    end
    if (s1 >= 0) begin
      code.format = bmcc_pkg::FMT_ONE_BIT; code.first_position = 5'(f1);
      code.dict_slot = 4'(s1);
    end else if (s2 >= 0) begin
      code.format = bmcc_pkg::FMT_TWO_CONS; code.first_position = 5'(f2);
      code.dict_slot = 4'(s2);
    end else if (s4 >= 0) begin
      code.format = bmcc_pkg::FMT_FOUR_CON; code.first_position = 5'(f4);
      code.dict_slot = 4'(s4);
    end else if (sb >= 0) begin
      code.format = bmcc_pkg::FMT_BITMASK; code.first_position = 5'(fb);
      code.mask = mb; code.dict_slot = 4'(sb);
    end else if (sa >= 0) begin
      code.format = bmcc_pkg::FMT_TWO_ANY; code.first_position = 5'(fa);
      code.second_position = 5'(la); code.dict_slot = 4'(sa);
    end else begin
      code.format = bmcc_pkg::FMT_RAW; code.raw_word = w;
    end
    return code;
  endfunction

  // Update the predicted state for one accepted request and queue its codes
  task automatic predict_request(input bmcc_pkg::request_t req);
    bmcc_pkg::result_t codes[$];
    bmcc_pkg::result_t code;
    case (req.action)
      bmcc_pkg::ACT_LOAD: dict_image[req.entry_slot] = req.word;
      bmcc_pkg::ACT_FLUSH: begin
        if (run_repeats > 0) begin
          code = '0; code.format = bmcc_pkg::FMT_RUN; code.run_count = 3'(run_repeats - 1);
          codes.insert(codes.size(), code);
          run_repeats = 0;
        end
        have_prev = 1'b0;
      end
      bmcc_pkg::ACT_COMPRESS: begin
        if (have_prev && req.word == prev_word && run_repeats < MAX_RUN) begin
          run_repeats++;
        end else begin
          if (run_repeats > 0) begin
            code = '0; code.format = bmcc_pkg::FMT_RUN; code.run_count = 3'(run_repeats - 1);
            codes.insert(codes.size(), code);
            run_repeats = 0;
          end
          codes.insert(codes.size(), encode_word(req.word));
          prev_word = req.word;
          have_prev = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < codes.size(); i++) begin
      code = codes[i];
      code.last = (i == codes.size() - 1);
      expected_codes.insert(expected_codes.size(), code);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  task automatic queue_request(input logic [1:0] action, input logic [3:0] slot,
                               input logic [31:0] word);
    bmcc_pkg::request_t req;
    req.action     = action;
    req.entry_slot = slot;
    req.word       = word;
    pending_requests.insert(pending_requests.size(), req);
    if (action == bmcc_pkg::ACT_LOAD) plan_dict[slot] = word;
    if (action == bmcc_pkg::ACT_COMPRESS) plan_last_word = word;
  endtask

  // Flip pattern for a given kind of near miss, position 0 being the MSB
  function automatic logic [31:0] flip_pattern(input int kind);
    logic [31:0] pat;
    logic [3:0]  bm;
    int          p, p2;
    pat = '0;
    case (kind)
      0: begin p = $urandom_range(0, 31); pat[31-p] = 1'b1; end
      1: begin p = $urandom_range(0, 30); pat = 32'h3 << (30 - p); end
      2: begin p = $urandom_range(0, 28); pat = 32'hF << (28 - p); end
      3: begin
        p  = $urandom_range(0, 31);
        bm = 4'($urandom_range(8, 15));
        for (int i = 0; i < 4; i++) begin
          if (bm[3-i] && p + i < WORD_BITS) pat[31-(p+i)] = 1'b1;
        end
      end
      default: begin
        p  = $urandom_range(0, 30);
        p2 = $urandom_range(p + 1, 31);
        pat[31-p]  = 1'b1;
        pat[31-p2] = 1'b1;
      end
    endcase
    return pat;
  endfunction

  // Request driver
  always @(posedge clk) begin
    bmcc_pkg::request_t next_req;
    logic     next_valid;
    int       send_gap;
    if (rst) begin
      request_ch.valid <= 1'b0;
      request_ch.data  <= '0;
      send_gap = 0;
    end else begin
      if (request_ch.valid && request_ch.ready) predict_request(request_ch.data);
      if (!request_ch.valid || request_ch.ready) begin
        next_valid = 1'b0;
        next_req   = '0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          next_req   = pending_requests.pop_front();
          next_valid = 1'b1;
          send_gap   = pick_idle();
        end
        request_ch.valid <= next_valid;
        if (next_valid) request_ch.data <= next_req;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    bmcc_pkg::result_t exp_code;
    bmcc_pkg::result_t got;
    int      stall_left;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual format %0h", $time,
                   got.format);
          mismatch_count++;
        end else begin
          exp_code = expected_codes.pop_front();
          check_field("format",          32'(exp_code.format),          32'(got.format));
          check_field("run_count",       32'(exp_code.run_count),       32'(got.run_count));
          check_field("first_position",  32'(exp_code.first_position),
                      32'(got.first_position));
          check_field("second_position", 32'(exp_code.second_position),
                      32'(got.second_position));
          check_field("mask",            32'(exp_code.mask),            32'(got.mask));
          check_field("dict_slot",       32'(exp_code.dict_slot),       32'(got.dict_slot));
          check_field("raw_word",        exp_code.raw_word,             got.raw_word);
          check_field("last",            32'(exp_code.last),            32'(got.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle();
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int       produced;
    int       r;
    int       kind;
    int       reps;
    logic [31:0] w;
    rst = 1'b1;

    // directed: load every entry, then one word per format and the corner cases
    queue_request(bmcc_pkg::ACT_LOAD, 4'd0, 32'h0000_0000);
    queue_request(bmcc_pkg::ACT_LOAD, 4'd1, 32'hFFFF_FFFF);
    queue_request(bmcc_pkg::ACT_LOAD, 4'd2, 32'hA5A5_5A5A);
    queue_request(bmcc_pkg::ACT_LOAD, 4'd3, 32'h1234_5678);
    for (int s = 4; s < DICT_ENTRIES; s++) queue_request(bmcc_pkg::ACT_LOAD, 4'(s), $urandom);
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'hA5A5_5A5A);   // dictionary hit
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd15, 32'h8000_0000);   // one bit at the MSB
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'hFFFF_FFFE);   // one bit at the LSB
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'h0000_0003);   // two consecutive
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'hF000_0000);   // four consecutive
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'h0000_0007);   // bitmask off the end
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'h8000_0001);   // two anywhere
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'h6DB6_DB6D);   // raw
    queue_request(bmcc_pkg::ACT_COMPRESS, 4'd0,  32'h6DB6_DB6D);   // single repeat
    queue_request(bmcc_pkg::ACT_FLUSH,    4'd0,  32'h0000_0000);   // flush with a run pending
    queue_request(bmcc_pkg::ACT_FLUSH,    4'hF,  32'hFFFF_FFFF);   // flush, nothing pending
    queue_request(ACT_UNUSED,             4'hA,  32'hDEAD_BEEF);   // ignored action

    // random part
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        // fresh dictionary, some entries close to earlier ones
        for (int s = 0; s < DICT_ENTRIES; s++) begin
          if (s > 0 && $urandom_range(0, 2) == 0)
            w = plan_dict[$urandom_range(0, s - 1)] ^ flip_pattern($urandom_range(0, 4));
          else
            w = $urandom;
          queue_request(bmcc_pkg::ACT_LOAD, 4'(s), w);
        end
        produced += DICT_ENTRIES;
      end else if (r < 6) begin
        if ($urandom_range(0, 1) == 0) w = $urandom;
        else w = plan_dict[$urandom_range(0, DICT_ENTRIES - 1)] ^
                 flip_pattern($urandom_range(0, 4));
        queue_request(bmcc_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), w);
        produced++;
      end else if (r < 11) begin
        queue_request(bmcc_pkg::ACT_FLUSH, 4'($urandom_range(0, 15)), $urandom);
        produced++;
      end else if (r < 13) begin
        queue_request(ACT_UNUSED, 4'($urandom_range(0, 15)), $urandom);
      end else if (r < 30) begin
        // run of repeats, sometimes past the full length
        reps = $urandom_range(1, 11);
        w = plan_last_word;
        for (int i = 0; i < reps; i++)
          queue_request(bmcc_pkg::ACT_COMPRESS, 4'($urandom_range(0, 15)), w);
        produced += reps;
      end else begin
        kind = $urandom_range(0, 7);
        w = plan_dict[$urandom_range(0, DICT_ENTRIES - 1)];
        case (kind)
          0: ;
          1, 2, 3, 4, 5: w = w ^ flip_pattern(kind - 1);
          6: w = $urandom;
          default: w = $urandom & $urandom & $urandom;
        endcase
        queue_request(bmcc_pkg::ACT_COMPRESS, 4'($urandom_range(0, 15)), w);
        produced++;
      end
    end
    queue_request(bmcc_pkg::ACT_FLUSH, 4'd0, 32'h0000_0000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || request_ch.valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_codes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_codes.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_codes.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bmcc_pkg.sv
hw/rtl/bmcc_stream_if.sv
hw/rtl/bmcc_cell.sv
hw/rtl/bitmask_code_compressor_unit.sv
test/bitmask_code_compressor_unit_test.sv
